// ----- src/assert_macros.svh -----
// Assertion macros for the checker, used by dspd_checker.sv.
// Each macro wraps one concurrent assertion clocked on clock, reset on reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- src/dspd_pkg.sv -----
// Package for the depth sorted polygon deferral unit.
// Types and codes used by the sort cell, divider and top level.
`default_nettype none
package dspd_pkg;
   localparam logic [1:0] REQ_ADD     = 2'd0;
   localparam logic [1:0] REQ_FLUSH   = 2'd1;
   localparam logic [1:0] REQ_SCENE   = 2'd2;
   localparam logic [1:0] REQ_DISCARD = 2'd3;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_REPLAY = 2'd2;

   // one held polygon as it travels through the sort chain
   typedef struct packed {
      logic        valid;
      logic [31:0] depth;
      logic [4:0]  slot;
      logic [7:0]  first;
      logic [8:0]  points;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_FLUSH, ST_ACCEPT, ST_REJECT
   } state_type;
endpackage
`default_nettype wire

// ----- src/dspd_div.sv -----
// Iterative signed divider: 40-bit dividend by 10-bit divisor, one bit a cycle.
// Truncates toward zero and saturates to signed 32 bits. Uses dspd_pkg.
`default_nettype none
module dspd_div import dspd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [39:0] dividend,
   input  wire logic [9:0]  divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [39:0] quo_ff, quo_in;
   logic [10:0] rem_ff, rem_in;
   logic [9:0]  den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [39:0] mag;
   logic [10:0] trial;
   logic [39:0] sq;

   assign mag = dividend[39] ? (~dividend + 40'd1) : dividend;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[9:0], quo_ff[39]};
      if (start) begin
         quo_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[39];
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = busy_ff == 1'b0;

   // for a nonzero divisor the magnitude is at most 2^39; saturate after sign
   always_comb begin
      sq = neg_ff ? (~quo_ff + 40'd1) : quo_ff;
      if (!neg_ff && quo_ff > 40'h007FFFFFFF)
         quotient = 32'h7FFFFFFF;
      else if (neg_ff && quo_ff > 40'h0080000000)
         quotient = 32'h80000000;
      else
         quotient = sq[31:0];
   end
endmodule
`default_nettype wire

// ----- src/dspd_cell.sv -----
// One cell of the insertion sort chain; holds one entry.
// On insert, takes the new entry or the entry of the cell above. Uses dspd_pkg.
`default_nettype none
module dspd_cell import dspd_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      clear,
   input  wire logic      insert,
   input  wire logic      shift,
   input  wire entry_type new_entry,
   input  wire entry_type prev_held,
   input  wire logic      prev_take,
   input  wire entry_type next_held,
   output logic           take,
   output entry_type      held
);
   entry_type held_ff, held_in;

   // strict compare keeps arrival order for equal depths
   assign take = new_entry.valid &&
      (!held_ff.valid || $signed(new_entry.depth) > $signed(held_ff.depth));

   // chain is sorted, so take is set from the insert point downward
   always_comb begin
      held_in = held_ff;
      if (clear) begin
         held_in.valid = 1'b0;
      end else if (shift) begin
         held_in = next_held;
      end else if (insert) begin
         if (prev_take)  held_in = prev_held;
         else if (take)  held_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) held_ff.valid <= 1'b0;
      else       held_ff.valid <= held_in.valid;
      held_ff.depth  <= held_in.depth;
      held_ff.slot   <= held_in.slot;
      held_ff.first  <= held_in.first;
      held_ff.points <= held_in.points;
   end

   assign held = held_ff;
endmodule
`default_nettype wire

// ----- src/depth_sorted_polygon_deferral_unit.sv -----
// Top level of the depth sorted polygon deferral unit.
// Uses dspd_pkg, dspd_div and a chain of dspd_cell.
//
//  channel | ports                                             | dir
//  request | req_valid req_stall req_type scene_id count depth | in
//  result  | rsp_valid rsp_stall rsp_kind slot first points last| out
//
// An add stalls the input from its transfer, through the 40 divider steps, until idle.
// A flush ahead of the accept first replays every entry the chain holds.
// A flush gives one replay entry a cycle from the chain head unless the result stalls.
// Entries enter the chain sorted; the chain has one cell per slot.
// Reset empties the chain and clears all counters. A stalled result holds.
`default_nettype none
module depth_sorted_polygon_deferral_unit import dspd_pkg::*; #(
   parameter int MAX_POLYS  = 32,
   parameter int MAX_POINTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_scene_id,
   input  wire logic [9:0]  req_point_count,
   input  wire logic [39:0] req_depth_sum,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [4:0]       rsp_slot,
   output logic [7:0]       rsp_first_point,
   output logic [8:0]       rsp_points,
   output logic             rsp_last
);
   localparam int PW = $clog2(MAX_POLYS + 1);
   localparam int NW = $clog2(MAX_POINTS + 1);

   state_type   state_ff, state_in;
   logic [1:0]  type_ff;
   logic [15:0] scene_ff;
   logic [9:0]  cnt_ff;
   logic        then_accept_ff, then_accept_in;
   logic [PW-1:0] npoly_ff, npoly_in;
   logic [NW-1:0] npts_ff, npts_in;
   logic [15:0] hscene_ff, hscene_in;
   logic        svalid_ff, svalid_in;
   logic        div_start, div_done;
   logic [31:0] quotient;
   logic        accept;
   logic        clear, insert, shift;
   logic        chain_empty;
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff, rk_in;
   logic [4:0]  rs_ff, rs_in;
   logic [7:0]  rf_ff, rf_in;
   logic [8:0]  rp_ff, rp_in;
   logic        rl_ff, rl_in;
   logic        out_free;
   logic [NW:0] pts_sum;
   logic        need_flush;
   entry_type   new_entry;
   entry_type   held [MAX_POLYS+1];
   logic [MAX_POLYS-1:0] take;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rv_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         scene_ff <= req_scene_id;
         cnt_ff   <= req_point_count;
      end
   end

   dspd_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(req_depth_sum),
      .divisor(req_point_count), .done(div_done), .quotient(quotient)
   );

   assign pts_sum    = {1'b0, npts_ff} + (NW+1)'(cnt_ff);
   assign need_flush = (npoly_ff >= PW'(MAX_POLYS)) || (pts_sum > (NW+1)'(MAX_POINTS));
   assign chain_empty = !held[0].valid;

   // next-state logic
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_ADD:
                     if (req_point_count == 10'd0 ||
                         req_point_count > 10'(MAX_POINTS)) state_in = ST_REJECT;
                     else state_in = ST_DIV;
                  REQ_FLUSH: state_in = ST_FLUSH;
                  REQ_SCENE: state_in = ST_FLUSH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV:    if (div_done && !div_start)
                       state_in = need_flush ? ST_FLUSH : ST_ACCEPT;
         ST_FLUSH:  if (chain_empty || (type_ff == REQ_SCENE &&
                       (scene_ff == hscene_ff) && !then_accept_ff))
                       state_in = then_accept_ff ? ST_ACCEPT : ST_IDLE;
         ST_ACCEPT: if (out_free) state_in = ST_IDLE;
         ST_REJECT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // output and datapath control
   always_comb begin
      div_start      = state_ff == ST_IDLE && accept && req_type == REQ_ADD;
      then_accept_in = then_accept_ff;
      npoly_in  = npoly_ff;
      npts_in   = npts_ff;
      hscene_in = hscene_ff;
      svalid_in = svalid_ff;
      clear  = 1'b0;
      insert = 1'b0;
      shift  = 1'b0;
      rv_in = rv_ff && rsp_stall;
      rk_in = rk_ff; rs_in = rs_ff; rf_in = rf_ff; rp_in = rp_ff; rl_in = rl_ff;
      new_entry.valid  = 1'b1;
      new_entry.depth  = quotient;
      new_entry.slot   = 5'(npoly_ff);
      new_entry.first  = 8'(npts_ff);
      new_entry.points = 9'(cnt_ff);
      case (state_ff)
         ST_IDLE: begin
            then_accept_in = 1'b0;
            if (accept && req_type == REQ_DISCARD) begin
               clear = 1'b1; npoly_in = '0; npts_in = '0;
               hscene_in = '0; svalid_in = 1'b0;
            end
         end
         ST_DIV: if (div_done && !div_start) then_accept_in = need_flush;
         ST_FLUSH: begin
            if (!chain_empty && !(type_ff == REQ_SCENE && scene_ff == hscene_ff &&
                !then_accept_ff) && out_free) begin
               rv_in = 1'b1; rk_in = KIND_REPLAY;
               rs_in = held[0].slot; rf_in = held[0].first; rp_in = held[0].points;
               rl_in = !then_accept_ff && !held[1].valid;
               shift = 1'b1;
               if (!held[1].valid) begin npoly_in = '0; npts_in = '0; end
            end
         end
         ST_ACCEPT: begin
            if (out_free) begin
               rv_in = 1'b1; rk_in = KIND_ACCEPT;
               rs_in = new_entry.slot; rf_in = new_entry.first;
               rp_in = new_entry.points; rl_in = 1'b1;
               insert = 1'b1;
               if (npoly_ff == '0) begin hscene_in = scene_ff; svalid_in = 1'b1; end
               npoly_in = npoly_ff + PW'(1);
               npts_in  = npts_ff + NW'(cnt_ff);
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rv_in = 1'b1; rk_in = KIND_REJECT;
               rs_in = '0; rf_in = '0; rp_in = '0; rl_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign held[MAX_POLYS] = '0;

   for (genvar g = 0; g < MAX_POLYS; g++) begin : g_cell
      entry_type prev_held;
      logic      prev_take;
      if (g == 0) begin : g_head
         assign prev_held = '0;
         assign prev_take = 1'b0;
      end else begin : g_link
         assign prev_held = held[g-1];
         assign prev_take = take[g-1];
      end
      dspd_cell u_cell (
         .clock(clock), .reset(reset), .clear(clear), .insert(insert),
         .shift(shift), .new_entry(new_entry), .prev_held(prev_held),
         .prev_take(prev_take), .next_held(held[g+1]),
         .take(take[g]), .held(held[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         then_accept_ff <= 1'b0;
         npoly_ff <= '0; npts_ff <= '0; hscene_ff <= '0; svalid_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         then_accept_ff <= then_accept_in;
         npoly_ff <= npoly_in; npts_ff <= npts_in;
         hscene_ff <= hscene_in; svalid_ff <= svalid_in;
         rv_ff <= rv_in;
      end
      rk_ff <= rk_in; rs_ff <= rs_in; rf_ff <= rf_in; rp_ff <= rp_in; rl_ff <= rl_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_result_kind = rk_ff;
   assign rsp_slot        = rs_ff;
   assign rsp_first_point = rf_ff;
   assign rsp_points      = rp_ff;
   assign rsp_last        = rl_ff;
endmodule
`default_nettype wire

// ----- src/dspd_checker.sv -----
// Port-level checker for the deferral unit, bound to the top level.
// Uses assert_macros.svh and dspd_pkg.
`default_nettype none
`include "assert_macros.svh"
module dspd_checker import dspd_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_result_kind,
   input wire logic [8:0] rsp_points,
   input wire logic       rsp_last
);
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMPL(a_kind_ok, rsp_valid, rsp_result_kind <= KIND_REPLAY)
   `ASSERT_IMPL(a_reject_last, rsp_valid && rsp_result_kind == KIND_REJECT,
      rsp_last && rsp_points == 9'd0)
   `ASSERT_IMPL(a_accept_last, rsp_valid && rsp_result_kind == KIND_ACCEPT, rsp_last)
   `ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall && rsp_valid && rsp_stall,
      rsp_valid)
endmodule

bind depth_sorted_polygon_deferral_unit dspd_checker u_dspd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_kind(rsp_result_kind),
   .rsp_points(rsp_points), .rsp_last(rsp_last)
);
`default_nettype wire
